### rtl/u8c_pkg.sv
// Shared types and constants for the UTF-8 / CESU-8 byte transcoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package u8c_pkg;

    localparam int GroupDepth = 6;
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    typedef logic [7:0] octet_t;
    typedef logic [2:0] cnt_t;

    localparam logic       DIR_TO_CESU   = 1'b0;
    localparam logic [3:0] LEAD4_NIB     = 4'hF;
    localparam logic [3:0] HI_SURR_NIB   = 4'hA;
    localparam logic [3:0] LO_SURR_NIB   = 4'hB;
    localparam logic [1:0] CONT_MARK     = 2'b10;
    localparam logic [4:0] UTF8_LEAD_MRK = 5'b11110;
    localparam octet_t     SURR_LEAD     = 8'hED;
    localparam cnt_t       UTF8_GROUP    = 3'd4;
    localparam cnt_t       CESU_GROUP    = 3'd6;

    typedef struct packed {
        logic [GroupDepth-1:0][7:0] data;
        cnt_t                       count;
        logic                       last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

### rtl/u8c_front.sv
// Front end: accepts input bytes, gathers multi-byte groups, and builds output jobs.
// Holds the direction register. Depends on u8c_pkg.
`default_nettype none

module u8c_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic          wr_data,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_string,
    output logic               push,
    output u8c_pkg::job_t      job
);
    import u8c_pkg::*;

    octet_t            group_reg  [GroupDepth];
    octet_t            group_next [GroupDepth];
    cnt_t              count_reg;
    cnt_t              count_next;
    logic              dir_reg;
    logic              dir_next;
    logic              job_valid;
    logic              lone;
    logic [GroupDepth-1:0][7:0] raw;
    logic [20:0]       cesu_v;
    logic [3:0]        cesu_plane;
    logic [4:0]        utf8_plane;
    logic [5:0][7:0]   cesu_bytes;
    logic [5:0][7:0]   utf8_bytes;

    always_comb
    begin
        for (int i = 0; i < GroupDepth; i++)
        begin
            raw[i] = (cnt_t'(i) < count_reg) ? group_reg[i] : data_byte;
        end

        cesu_v     = {group_reg[0][2:0], group_reg[1][5:0], group_reg[2][5:0], data_byte[5:0]};
        cesu_plane = cesu_v[19:16] - 4'd1;
        cesu_bytes[0] = SURR_LEAD;
        cesu_bytes[1] = {HI_SURR_NIB, cesu_plane};
        cesu_bytes[2] = {CONT_MARK, cesu_v[15:10]};
        cesu_bytes[3] = SURR_LEAD;
        cesu_bytes[4] = {LO_SURR_NIB, cesu_v[9:6]};
        cesu_bytes[5] = {CONT_MARK, cesu_v[5:0]};

        utf8_plane = {1'b0, group_reg[1][3:0]} + 5'd1;
        utf8_bytes[0] = {UTF8_LEAD_MRK, utf8_plane[4:2]};
        utf8_bytes[1] = {CONT_MARK, utf8_plane[1:0], group_reg[2][5:2]};
        utf8_bytes[2] = {CONT_MARK, group_reg[2][1:0], group_reg[4][3:0]};
        utf8_bytes[3] = {CONT_MARK, data_byte[5:0]};
        utf8_bytes[4] = 8'h00;
        utf8_bytes[5] = 8'h00;
    end

    always_comb
    begin
        group_next = group_reg;
        count_next = count_reg;
        dir_next   = dir_reg;
        job_valid  = 1'b0;
        job.data   = raw;
        job.count  = 3'd1;
        job.last   = end_of_string;
        lone       = (count_reg == 3'd1) && (data_byte[7:4] != HI_SURR_NIB);

        if (wr_en)
        begin
            dir_next   = wr_data;
            count_next = '0;
        end
        else if (accept)
        begin
            if (dir_reg == DIR_TO_CESU)
            begin
                if (count_reg == '0)
                begin
                    if ((data_byte[7:4] == LEAD4_NIB) && !end_of_string)
                    begin
                        group_next[0] = data_byte;
                        count_next    = 3'd1;
                    end
                    else
                    begin
                        job_valid = 1'b1;
                    end
                end
                else
                begin
                    group_next[count_reg] = data_byte;
                    if (count_reg == UTF8_GROUP - 3'd1)
                    begin
                        job_valid  = 1'b1;
                        job.data   = cesu_bytes;
                        job.count  = CESU_GROUP;
                        count_next = '0;
                    end
                    else if (end_of_string)
                    begin
                        job_valid  = 1'b1;
                        job.count  = count_reg + 3'd1;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
            end
            else
            begin
                if ((count_reg == '0) || lone)
                begin
                    if ((data_byte == SURR_LEAD) && !end_of_string)
                    begin
                        group_next[0] = data_byte;
                        count_next    = 3'd1;
                        if (lone)
                        begin
                            job_valid = 1'b1;
                            job.last  = 1'b0;
                        end
                    end
                    else
                    begin
                        job_valid  = 1'b1;
                        job.count  = lone ? 3'd2 : 3'd1;
                        count_next = '0;
                    end
                end
                else
                begin
                    group_next[count_reg] = data_byte;
                    if (count_reg == CESU_GROUP - 3'd1)
                    begin
                        job_valid  = 1'b1;
                        job.data   = utf8_bytes;
                        job.count  = UTF8_GROUP;
                        count_next = '0;
                    end
                    else if (end_of_string)
                    begin
                        job_valid  = 1'b1;
                        job.count  = count_reg + 3'd1;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
            end
        end
    end

    assign push = job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dir_reg   <= DIR_TO_CESU;
        end
        else
        begin
            count_reg <= count_next;
            dir_reg   <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

endmodule

`default_nettype wire

### rtl/u8c_queue.sv
// Short job queue between the front end and the back end.
// Depends on u8c_pkg.
`default_nettype none

module u8c_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire u8c_pkg::job_t  push_job,
    input  wire logic           pop,
    output u8c_pkg::job_t       head,
    output u8c_pkg::q_status_t  status
);
    import u8c_pkg::*;

    job_t              mem_reg [QueueDepth];
    logic [QPtrW-1:0]  wr_ptr_reg;
    logic [QPtrW-1:0]  wr_ptr_next;
    logic [QPtrW-1:0]  rd_ptr_reg;
    logic [QPtrW-1:0]  rd_ptr_next;
    logic [QCntW-1:0]  count_reg;
    logic [QCntW-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCntW'(QueueDepth));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### rtl/u8c_back.sv
// Back end: walks the head job one byte per cycle into the output register
// unless out_stall holds it. Depends on u8c_pkg.
`default_nettype none

module u8c_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire u8c_pkg::job_t       head,
    input  wire u8c_pkg::q_status_t  status,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               out_byte,
    output logic                     out_last
);
    import u8c_pkg::*;

    cnt_t    idx_reg;
    cnt_t    idx_next;
    logic    valid_reg;
    logic    valid_next;
    octet_t  byte_reg;
    logic    last_reg;
    logic    load;
    logic    at_end;

    assign at_end = (idx_reg == head.count - 3'd1);
    assign load   = !status.empty && (!valid_reg || !out_stall);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = at_end ? '0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.data[idx_reg];
            last_reg <= head.last && at_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

### rtl/utf8_cesu8_byte_transcoder_core.sv
// UTF-8 / CESU-8 byte transcoder, top level: front end, two-entry job queue, back end.
// Path: a finished job goes into the queue, then its bytes into the output register.
// Throughput: one input byte per cycle while the queue has room; one output byte per cycle,
// unless stalled, set by the single output register; four UTF-8 bytes give six.
// Reset: asynchronous active low; clears direction (UTF-8 to CESU-8), group count, queue.
// Depends on u8c_pkg, u8c_front, u8c_queue, u8c_back.
`default_nettype none

module utf8_cesu8_byte_transcoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic        wr_data,
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_string,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_last
);
    import u8c_pkg::*;

    job_t       front_job;
    job_t       q_head;
    q_status_t  q_status;
    logic       accept;
    logic       front_push;
    logic       q_push;
    logic       q_pop;

    assign data_stall = q_status.full;
    assign accept     = data_valid && !data_stall;
    assign q_push     = accept && front_push;

    u8c_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_data       (wr_data),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .push          (front_push),
        .job           (front_job)
    );

    u8c_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    u8c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .status    (q_status),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.empty |-> ((q_head.count != 3'd0) && (q_head.count <= CESU_GROUP)))
        else $error("queued job has bad byte count");

    a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid)
        else $error("job retired without output transaction");

endmodule

`default_nettype wire

### tb/tb_utf8_cesu8_byte_transcoder_core.sv
// Self-checking regression for utf8_cesu8_byte_transcoder_core: directed table, then random strings
// in both directions under three sender/receiver idle profiles, checked by a byte-level predictor.
// Depends on u8c_pkg and the transcoder RTL only.
`default_nettype none

module tb_utf8_cesu8_byte_transcoder_core;

    import u8c_pkg::*;

    localparam logic DIR_TO_UTF8 = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   SEG_ITEMS   = 25;
    localparam int   N_ROWS      = 27;

    typedef struct packed {
        octet_t data;
        logic   last;
    } obyte_t;

    typedef struct packed {
        logic   dir;
        octet_t data;
        logic   eos;
        logic   has_lit;
        octet_t lit_data;
        logic   lit_last;
    } plan_row_t;

    typedef octet_t octet_q_t[$];

    localparam plan_row_t PLAN [N_ROWS] = '{
        '{DIR_TO_CESU, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1},
        '{DIR_TO_CESU, 8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'h9F, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'hF8, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{DIR_TO_CESU, 8'hF4, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_CESU, 8'h8F, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hED, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hAF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hED, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hBF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hED, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hB0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hED, 1'b1, 1'b1, 8'hED, 1'b1},
        '{DIR_TO_UTF8, 8'hED, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hED, 1'b0, 1'b0, 8'h00, 1'b0},
        '{DIR_TO_UTF8, 8'hA0, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    localparam logic DIR_PLAN [6] = '{DIR_TO_CESU, DIR_TO_UTF8, DIR_TO_UTF8,
                                      DIR_TO_CESU, DIR_TO_CESU, DIR_TO_UTF8};

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       wr_en         = 1'b0;
    logic       wr_data       = 1'b0;
    logic       data_valid    = 1'b0;
    logic [7:0] data_byte     = 8'h00;
    logic       end_of_string = 1'b0;
    logic       out_stall     = 1'b0;
    logic       data_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;

    octet_t grp_buf [GroupDepth];
    cnt_t   grp_cnt = '0;
    logic   dir_q   = DIR_TO_CESU;

    obyte_t due_bytes[$];
    obyte_t fresh_bytes[$];

    int src_pct   = 0;
    int snk_pct   = 0;
    int cyc       = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_cfg     = 0;
    int n_bad     = 0;

    utf8_cesu8_byte_transcoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_data       (wr_data),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .out_last      (out_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still due", cyc, due_bytes.size());
            $display("utf8_cesu8_byte_transcoder_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < snk_pct);
    end

    task automatic report_mismatch(input string what);
        n_bad++;
        if (n_bad <= 50)
            $display("mismatch at cycle %0d: %s", cyc, what);
    endtask

    always @(negedge clk)
    begin : check_out
        obyte_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output byte %02h", out_byte));
            end
            else
            begin
                due = due_bytes.pop_front();
                if (out_byte !== due.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, due.data));
                if (out_last !== due.last)
                    report_mismatch($sformatf("out_last %b, expected %b on byte %02h",
                                              out_last, due.last, due.data));
                n_checked++;
            end
        end
    end

    function automatic void push_byte(input octet_t b, input logic l);
        obyte_t o;
        o.data = b;
        o.last = l;
        fresh_bytes.push_back(o);
    endfunction

    function automatic void flush_group(input logic e);
        for (int i = 0; i < int'(grp_cnt); i++)
            push_byte(grp_buf[i], (i == int'(grp_cnt) - 1) ? e : 1'b0);
        grp_cnt = '0;
    endfunction

    function automatic void emit_surrogates(input logic e);
        logic [20:0] cp;
        logic [3:0]  plane_m1;
        cp = {grp_buf[0][2:0], grp_buf[1][5:0], grp_buf[2][5:0], grp_buf[3][5:0]};
        plane_m1 = cp[19:16] - 4'd1;
        push_byte(SURR_LEAD, 1'b0);
        push_byte({HI_SURR_NIB, plane_m1}, 1'b0);
        push_byte({CONT_MARK, cp[15:10]}, 1'b0);
        push_byte(SURR_LEAD, 1'b0);
        push_byte({LO_SURR_NIB, cp[9:6]}, 1'b0);
        push_byte({CONT_MARK, cp[5:0]}, e);
        grp_cnt = '0;
    endfunction

    function automatic void emit_four_byte(input logic e);
        logic [4:0]  plane;
        logic [20:0] cp;
        plane = {1'b0, grp_buf[1][3:0]} + 5'd1;
        cp = {plane, grp_buf[2][5:0], grp_buf[4][3:0], grp_buf[5][5:0]};
        push_byte({UTF8_LEAD_MRK, cp[20:18]}, 1'b0);
        push_byte({CONT_MARK, cp[17:12]}, 1'b0);
        push_byte({CONT_MARK, cp[11:6]}, 1'b0);
        push_byte({CONT_MARK, cp[5:0]}, e);
        grp_cnt = '0;
    endfunction

    function automatic void transcode_byte(input octet_t b, input logic e);
        if (grp_cnt > 3'd5)
            grp_cnt = '0;
        if (dir_q == DIR_TO_CESU)
        begin
            if (grp_cnt == '0)
            begin
                if (b[7:4] == LEAD4_NIB && !e)
                begin
                    grp_buf[0] = b;
                    grp_cnt = 3'd1;
                end
                else
                begin
                    push_byte(b, e);
                end
            end
            else
            begin
                grp_buf[grp_cnt] = b;
                grp_cnt = grp_cnt + 3'd1;
                if (grp_cnt == UTF8_GROUP)
                    emit_surrogates(e);
                else if (e)
                    flush_group(e);
            end
        end
        else
        begin
            if (grp_cnt == 3'd1 && b[7:4] != HI_SURR_NIB)
            begin
                push_byte(grp_buf[0], 1'b0);
                grp_cnt = '0;
            end
            if (grp_cnt == '0)
            begin
                if (b == SURR_LEAD && !e)
                begin
                    grp_buf[0] = b;
                    grp_cnt = 3'd1;
                end
                else
                begin
                    push_byte(b, e);
                end
            end
            else
            begin
                grp_buf[grp_cnt] = b;
                grp_cnt = grp_cnt + 3'd1;
                if (grp_cnt == CESU_GROUP)
                    emit_four_byte(e);
                else if (e)
                    flush_group(e);
            end
        end
    endfunction

    task automatic send_item(input octet_t b, input logic e, input logic lit_on,
                             input obyte_t lit);
        logic acc;
        while ($urandom_range(0, 99) < src_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid    <= 1'b1;
        data_byte     <= b;
        end_of_string <= e;
        acc = 1'b0;
        while (!acc)
        begin
            @(negedge clk);
            acc = !data_stall;
            @(posedge clk);
        end
        fresh_bytes.delete();
        transcode_byte(b, e);
        if (lit_on)
            due_bytes.push_back(lit);
        else
            foreach (fresh_bytes[i])
                due_bytes.push_back(fresh_bytes[i]);
        n_sent++;
    endtask

    task automatic set_direction(input logic d);
        data_valid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        wr_en   <= 1'b1;
        wr_data <= d;
        @(posedge clk);
        wr_en   <= 1'b0;
        dir_q   = d;
        grp_cnt = '0;
        n_cfg++;
    endtask

    function automatic octet_t cont_byte();
        logic [5:0] low6;
        low6 = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 7) == 0)
            return octet_t'($urandom_range(0, 255));
        return {CONT_MARK, low6};
    endfunction

    function automatic octet_q_t make_group();
        octet_q_t   g;
        logic [3:0] nib;
        nib = 4'($urandom_range(0, 15));
        if (dir_q == DIR_TO_CESU)
        begin
            if ($urandom_range(0, 3) == 0)
                g.push_back({LEAD4_NIB, nib});
            else
                g.push_back(8'hF0 + octet_t'($urandom_range(0, 4)));
            repeat (3) g.push_back(cont_byte());
        end
        else
        begin
            g.push_back(SURR_LEAD);
            g.push_back({HI_SURR_NIB, nib});
            g.push_back(cont_byte());
            g.push_back(($urandom_range(0, 7) == 0) ? octet_t'($urandom_range(0, 255))
                                                     : SURR_LEAD);
            nib = 4'($urandom_range(0, 15));
            g.push_back({LO_SURR_NIB, nib});
            g.push_back(cont_byte());
        end
        return g;
    endfunction

    task automatic send_string(input int n_tok);
        octet_q_t s;
        octet_q_t g;
        int       k;
        obyte_t   none;
        none = '0;
        for (int t = 0; t < n_tok; t++)
        begin
            g.delete();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    g = make_group();
                7:
                begin
                    g = make_group();
                    k = $urandom_range(1, g.size() - 1);
                    while (g.size() > k)
                        void'(g.pop_back());
                end
                8:
                begin
                    if (dir_q == DIR_TO_UTF8)
                        g.push_back(SURR_LEAD);
                    g.push_back(octet_t'($urandom_range(0, 127)));
                end
                default:
                    g.push_back(octet_t'($urandom_range(0, 255)));
            endcase
            foreach (g[i])
                s.push_back(g[i]);
        end
        foreach (s[i])
            send_item(s[i], (i == s.size() - 1), 1'b0, none);
    endtask

    initial
    begin
        int     seg_start;
        obyte_t lit;
        src_pct = 21;
        snk_pct = 50;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (PLAN[r].dir != dir_q)
                set_direction(PLAN[r].dir);
            lit.data = PLAN[r].lit_data;
            lit.last = PLAN[r].lit_last;
            send_item(PLAN[r].data, PLAN[r].eos, PLAN[r].has_lit, lit);
        end

        for (int m = 0; m < 3; m++)
        begin
            src_pct = (m == 0) ? 21 : (m == 1) ? 50 : 0;
            snk_pct = (m == 0) ? 50 : (m == 1) ? 21 : 0;
            for (int h = 0; h < 2; h++)
            begin
                set_direction(DIR_PLAN[m * 2 + h]);
                seg_start = n_sent;
                while (n_sent - seg_start < SEG_ITEMS)
                    send_string($urandom_range(1, 6));
            end
        end

        data_valid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d input bytes, checked %0d output bytes, %0d direction writes",
                 n_sent, n_checked, n_cfg);
        $display("both directions, grouped/truncated/lone-lead strings, three idle profiles");
        if (n_bad == 0)
        begin
            $display("utf8_cesu8_byte_transcoder_core regression: pass");
        end
        else
        begin
            $display("%0d mismatches", n_bad);
            $display("utf8_cesu8_byte_transcoder_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
